@@ design/erpm_pkg.sv @@
// Shared types and constants for the encoder RPM estimator.
// No dependencies; every other design file imports this package.
package erpm_pkg;

    // Encoder counter width used for masking the incoming count.
    localparam int COUNT_BITS = 16;

    // Field widths fixed by the interface.
    localparam int ENC_BITS    = 16;
    localparam int TIME_BITS   = 32;
    localparam int RPM_BITS    = 13;
    localparam int CPR_BITS    = 16;
    localparam int PERIOD_BITS = 10;

    localparam logic [ENC_BITS-1:0] COUNT_MASK =
        (COUNT_BITS >= ENC_BITS) ? {ENC_BITS{1'b1}}
                                 : ENC_BITS'((64'd1 << COUNT_BITS) - 64'd1);

    // Signed count difference and the wrap-corrected magnitude.
    localparam int DIFF_BITS = ENC_BITS + 2;
    localparam int MAG_BITS  = ENC_BITS;

    // freq = 1000 / elapsed never exceeds 1000.
    localparam int FREQ_BITS = 10;
    localparam int FCNT_BITS = $clog2(FREQ_BITS + 1);

    // |diff| * freq, then * 60, then plus the rounding bias.
    localparam int PROD_BITS = MAG_BITS + FREQ_BITS;
    localparam int SCL_BITS  = PROD_BITS + 6;
    localparam int NUM_BITS  = SCL_BITS + 1;

    // Shared divider.
    localparam int DIVS_BITS = 16;
    localparam int ITER_BITS = $clog2(NUM_BITS + 1);
    localparam logic [ITER_BITS-1:0] FREQ_ITERS = ITER_BITS'(FREQ_BITS);
    localparam logic [ITER_BITS-1:0] QUOT_ITERS = ITER_BITS'(NUM_BITS);

    localparam int MS_PER_S  = 1000;
    localparam int RPM_LIMIT = 3000;

    // Configuration port.
    localparam int CFG_IDX_BITS  = 8;
    localparam int CFG_DATA_BITS = 16;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_CPR    = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_PERIOD = CFG_IDX_BITS'(1);

    localparam logic [CPR_BITS-1:0]    CPR_RESET    = CPR_BITS'(1024);
    localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = PERIOD_BITS'(10);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_WRAP,
        S_FDIV,
        S_MUL,
        S_PREP,
        S_QDIV,
        S_DONE
    } t_state;

endpackage

@@ design/erpm_serdiv.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on erpm_pkg for widths.
module erpm_serdiv import erpm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [ITER_BITS-1:0] i_iters,
    input  logic [NUM_BITS-1:0]  i_dividend,
    input  logic [DIVS_BITS-1:0] i_divisor,
    output logic                 o_done,
    output logic [NUM_BITS-1:0]  o_quot
);

    logic                 r_busy;
    logic                 r_done;
    logic [ITER_BITS-1:0] r_cnt;
    logic [NUM_BITS-1:0]  r_quot;
    logic [DIVS_BITS-1:0] r_rem;
    logic [DIVS_BITS-1:0] r_div;

    logic [DIVS_BITS:0] w_trial;
    logic [DIVS_BITS:0] w_diff;
    logic               w_fit;

    // Shift the next dividend bit into the partial remainder and try a subtract.
    always_comb begin
        w_trial = {r_rem, r_quot[NUM_BITS-1]};
        w_diff  = w_trial - {1'b0, r_div};
        w_fit   = (w_trial >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_iters;
            end else if (r_busy) begin
                r_cnt <= r_cnt - ITER_BITS'(1);
                if (r_cnt == ITER_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[NUM_BITS-2:0], w_fit};
            r_rem  <= w_fit ? w_diff[DIVS_BITS-1:0] : w_trial[DIVS_BITS-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

@@ design/erpm_sermul.sv @@
// Bit-serial shift-add multiplier: magnitude times frequency, one bit per cycle.
// Depends on erpm_pkg for widths.
module erpm_sermul import erpm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [MAG_BITS-1:0]  i_mcand,
    input  logic [FREQ_BITS-1:0] i_mplier,
    output logic                 o_done,
    output logic [PROD_BITS-1:0] o_prod
);

    logic                 r_busy;
    logic                 r_done;
    logic [FCNT_BITS-1:0] r_cnt;
    logic [PROD_BITS-1:0] r_acc;
    logic [PROD_BITS-1:0] r_mcand;
    logic [FREQ_BITS-1:0] r_mplier;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= FCNT_BITS'(FREQ_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - FCNT_BITS'(1);
                if (r_cnt == FCNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Add the shifted multiplicand wherever the low multiplier bit is set.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc    <= '0;
            r_mcand  <= PROD_BITS'(i_mcand);
            r_mplier <= i_mplier;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= {r_mcand[PROD_BITS-2:0], 1'b0};
            r_mplier <= {1'b0, r_mplier[FREQ_BITS-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

@@ design/encoder_rpm_estimator.sv @@
// Encoder speed estimator: top level with control sequencer and state.
// Depends on erpm_pkg, erpm_serdiv and erpm_sermul.
//
// Usage:
//   Input stream (s_axis): one transaction per sample, carrying the encoder
//   count and the millisecond time stamp. Output stream (m_axis): exactly one
//   transaction per input, carrying the held RPM and an updated flag.
//   Config channel (i_cfg_*): write counts_per_rev (index 0) or
//   min_period_ms (index 1) while the block is idle; always ready.
// Operation:
//   A sample with no update due goes from the evaluation state straight to the
//   final state. An update runs a 10-step serial divide for 1000/elapsed, a
//   10-step serial multiply and a 33-step serial divide by counts_per_rev,
//   all one bit per cycle through the shared divider and the shift-add
//   multiplier; the first divide is skipped when elapsed exceeds one second.
//   One sample is in work at a time; the next is taken once the result sits
//   in the output register.
// Reset:
//   Synchronous, active low. Clears last count, last time and held RPM,
//   sets counts_per_rev to 1024 and min_period_ms to 10, empties the output.
// Stall:
//   A result waits in the output register while m_axis_tready is low; the
//   next sample may be taken and processed, and holds in the final state
//   until the output register frees.
module encoder_rpm_estimator import erpm_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Input stream
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [47:0]              s_axis_tdata,   // [15:0] encoder_count, [47:16] now_ms
    // Output stream
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [15:0]              m_axis_tdata,   // [12:0] rpm, [15:13] zero
    output logic                     m_axis_tuser,   // [0] updated
    // Configuration writes
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    // Configuration registers.
    logic [CPR_BITS-1:0]    r_cpr;
    logic [PERIOD_BITS-1:0] r_period;

    // Persistent estimator state.
    logic [ENC_BITS-1:0]        r_last_count;
    logic [TIME_BITS-1:0]       r_last_time;
    logic signed [RPM_BITS-1:0] r_held_rpm;

    // Sample in work and intermediate values.
    t_state                    r_state;
    t_state                    n_state;
    logic [ENC_BITS-1:0]       r_count;
    logic [TIME_BITS-1:0]      r_now;
    logic signed [DIFF_BITS-1:0] r_diff;
    logic                      r_fzero;
    logic                      r_neg;
    logic [MAG_BITS-1:0]       r_mag;
    logic [SCL_BITS-1:0]       r_scaled;
    logic                      r_qneg;
    logic signed [RPM_BITS-1:0] r_res_rpm;
    logic                      r_res_upd;

    // Output register.
    logic                      r_out_valid;
    logic [RPM_BITS-1:0]       r_out_rpm;
    logic                      r_out_upd;

    // Combinational helpers.
    logic [TIME_BITS-1:0]      w_elapsed;
    logic [PERIOD_BITS-1:0]    w_period;
    logic                      w_due;
    logic [CPR_BITS-1:0]       w_cpr;
    logic [CPR_BITS-1:0]       w_half;
    logic [DIFF_BITS-1:0]      w_abs;
    logic signed [DIFF_BITS-1:0] w_fixed;
    logic [DIFF_BITS-1:0]      w_fabs;
    logic [SCL_BITS-1:0]       w_halfx;
    logic [NUM_BITS-1:0]       w_num;
    logic                      w_num_neg;
    logic [NUM_BITS-1:0]       w_sat;
    logic [RPM_BITS-1:0]       w_mag_rpm;
    logic                      w_out_free;

    // Serial unit hookup.
    logic                 w_div_start;
    logic [ITER_BITS-1:0] w_div_iters;
    logic [NUM_BITS-1:0]  w_div_dividend;
    logic [DIVS_BITS-1:0] w_div_divisor;
    logic                 w_div_done;
    logic [NUM_BITS-1:0]  w_div_quot;
    logic                 w_mul_start;
    logic [FREQ_BITS-1:0] w_mul_mplier;
    logic                 w_mul_done;
    logic [PROD_BITS-1:0] w_mul_prod;

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    // Frequency straight from the divider as it finishes; zero past one second.
    assign w_mul_mplier  = r_fzero ? '0 : w_div_quot[FREQ_BITS-1:0];

    // Update test and wrap correction.
    always_comb begin
        w_elapsed = r_now - r_last_time;
        w_period  = (r_period == '0) ? PERIOD_BITS'(1) : r_period;
        w_due     = (w_elapsed >= TIME_BITS'(w_period));
        w_cpr     = (r_cpr < CPR_BITS'(2)) ? CPR_BITS'(2) : r_cpr;
        w_half    = {1'b0, w_cpr[CPR_BITS-1:1]};
        w_abs     = r_diff[DIFF_BITS-1] ? DIFF_BITS'(-r_diff) : DIFF_BITS'(r_diff);
        // Move a wrapped difference by one revolution toward zero.
        if (w_abs > DIFF_BITS'(w_half)) begin
            if (r_diff > 0) begin
                w_fixed = r_diff - $signed(DIFF_BITS'(w_cpr));
            end else begin
                w_fixed = r_diff + $signed(DIFF_BITS'(w_cpr));
            end
        end else begin
            w_fixed = r_diff;
        end
        w_fabs = w_fixed[DIFF_BITS-1] ? DIFF_BITS'(-w_fixed) : DIFF_BITS'(w_fixed);
    end

    // Rounding bias, sign of the numerator and saturation of the quotient.
    always_comb begin
        w_halfx = SCL_BITS'(w_half);
        if (!r_neg) begin
            w_num     = NUM_BITS'(r_scaled) + NUM_BITS'(w_halfx);
            w_num_neg = 1'b0;
        end else if (r_scaled > w_halfx) begin
            w_num     = NUM_BITS'(r_scaled - w_halfx);
            w_num_neg = 1'b1;
        end else begin
            w_num     = NUM_BITS'(w_halfx - r_scaled);
            w_num_neg = 1'b0;
        end
        w_sat = (w_div_quot > NUM_BITS'(RPM_LIMIT)) ? NUM_BITS'(RPM_LIMIT) : w_div_quot;
        w_mag_rpm = w_sat[RPM_BITS-1:0];
    end

    // Next state and unit strobes.
    always_comb begin
        n_state        = r_state;
        w_div_start    = 1'b0;
        w_div_iters    = FREQ_ITERS;
        w_div_dividend = NUM_BITS'(MS_PER_S) << (NUM_BITS - FREQ_BITS);
        w_div_divisor  = DIVS_BITS'(w_elapsed[FREQ_BITS-1:0]);
        w_mul_start    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (!w_due) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_WRAP;
                    // Skip the divide when elapsed exceeds one second: freq is zero.
                    w_div_start = (w_elapsed <= TIME_BITS'(MS_PER_S));
                end
            end
            S_WRAP: begin
                n_state = S_FDIV;
            end
            S_FDIV: begin
                if (r_fzero || w_div_done) begin
                    n_state     = S_MUL;
                    w_mul_start = 1'b1;
                end
            end
            S_MUL: begin
                if (w_mul_done) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_state        = S_QDIV;
                w_div_start    = 1'b1;
                w_div_iters    = QUOT_ITERS;
                w_div_dividend = w_num;
                w_div_divisor  = DIVS_BITS'(w_cpr);
            end
            S_QDIV: begin
                if (w_div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state, configuration and estimator state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cpr        <= CPR_RESET;
            r_period     <= PERIOD_RESET;
            r_last_count <= '0;
            r_last_time  <= '0;
            r_held_rpm   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_IDX_CPR) begin
                    r_cpr <= i_cfg_data[CPR_BITS-1:0];
                end else if (i_cfg_index == CFG_IDX_PERIOD) begin
                    r_period <= i_cfg_data[PERIOD_BITS-1:0];
                end
            end
            // Commit the new speed and advance the reference point.
            if (r_state == S_QDIV && w_div_done) begin
                r_held_rpm   <= r_qneg ? -$signed(w_mag_rpm) : $signed(w_mag_rpm);
                r_last_count <= r_count;
                r_last_time  <= r_now;
            end
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    r_count <= s_axis_tdata[ENC_BITS-1:0] & COUNT_MASK;
                    r_now   <= s_axis_tdata[ENC_BITS +: TIME_BITS];
                end
            end
            S_EVAL: begin
                r_diff    <= $signed(DIFF_BITS'(r_count)) - $signed(DIFF_BITS'(r_last_count));
                r_fzero   <= (w_elapsed > TIME_BITS'(MS_PER_S));
                r_res_rpm <= r_held_rpm;
                r_res_upd <= 1'b0;
            end
            S_WRAP: begin
                r_neg <= w_fixed[DIFF_BITS-1];
                r_mag <= w_fabs[MAG_BITS-1:0];
            end
            S_MUL: begin
                // Times sixty as 64x - 4x.
                if (w_mul_done) begin
                    r_scaled <= {w_mul_prod, 6'b0} - SCL_BITS'({w_mul_prod, 2'b0});
                end
            end
            S_PREP: begin
                r_qneg <= w_num_neg;
            end
            S_QDIV: begin
                if (w_div_done) begin
                    r_res_rpm <= r_qneg ? -$signed(w_mag_rpm) : $signed(w_mag_rpm);
                    r_res_upd <= 1'b1;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_out_rpm <= r_res_rpm;
                    r_out_upd <= r_res_upd;
                end
            end
            default: begin
            end
        endcase
    end

    erpm_serdiv u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_iters    (w_div_iters),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot)
    );

    erpm_sermul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_mul_start),
        .i_mcand  (r_mag),
        .i_mplier (w_mul_mplier),
        .o_done   (w_mul_done),
        .o_prod   (w_mul_prod)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = 16'(r_out_rpm);
    assign m_axis_tuser  = r_out_upd;

endmodule

@@ dv/encoder_rpm_estimator_tb.sv @@
// Self-checking testbench for encoder_rpm_estimator: directed table, then random phases.
// Depends on erpm_pkg and the encoder_rpm_estimator RTL with its erpm_serdiv and erpm_sermul.
`timescale 1ns / 1ps

module encoder_rpm_estimator_tb;
    import erpm_pkg::*;

    localparam int RANDOM_SAMPLES = 1130;  // random part, on top of the directed table
    localparam int SETTLE_CYCLES  = 80;
    localparam int S_PER_MIN      = 60;
    localparam int MAX_REPORTS    = 40;

    // One result transaction: held speed plus the new-value flag.
    typedef struct packed {
        logic signed [RPM_BITS-1:0] rpm;
        logic                       upd;
    } t_speed;

    typedef enum logic {
        ROW_SAMPLE,
        ROW_CFG
    } t_row_kind;

    // Directed stimulus row: either a register write or a sample, the latter with
    // an optional hand-computed expectation.
    typedef struct packed {
        t_row_kind                  kind;
        logic [CFG_IDX_BITS-1:0]    idx;
        logic [CFG_DATA_BITS-1:0]   data;
        logic [ENC_BITS-1:0]        count;
        logic [TIME_BITS-1:0]       now;
        logic                       typed;
        logic signed [RPM_BITS-1:0] rpm;
        logic                       upd;
    } t_dir_row;

    typedef enum int {
        RDY_ALWAYS,
        RDY_RANDOM,
        RDY_BURSTY
    } t_ready_mode;

    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [47:0]              s_axis_tdata  = '0;   // [15:0] encoder_count, [47:16] now_ms
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [15:0]              m_axis_tdata;         // [12:0] rpm, [15:13] zero
    logic                     m_axis_tuser;         // [0] updated
    logic                     i_cfg_valid   = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data    = '0;

    // Speed estimator state as the block should hold it.
    logic [CPR_BITS-1:0]        est_cpr       = CPR_RESET;
    logic [PERIOD_BITS-1:0]     est_period    = PERIOD_RESET;
    logic [ENC_BITS-1:0]        est_last_count = '0;
    logic [TIME_BITS-1:0]       est_last_ms   = '0;
    logic signed [RPM_BITS-1:0] est_held_rpm  = '0;

    t_speed   expected_speeds[$];
    t_speed   front_speed;
    t_dir_row dir_table[$];
    int       mismatches = 0;

    // Receiver stall pattern.
    t_ready_mode ready_mode = RDY_ALWAYS;
    int          ready_left = 0;
    int          stall_left = 0;

    encoder_rpm_estimator u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Advance the estimator by one sample and return the result it owes.
    function automatic t_speed estimate_speed(input logic [ENC_BITS-1:0]  raw_count,
                                              input logic [TIME_BITS-1:0] now);
        logic [ENC_BITS-1:0]  cnt;
        logic [TIME_BITS-1:0] elapsed;
        longint               period, cpr, diff, mag, freq, r;
        t_speed               res;
        cnt     = raw_count & COUNT_MASK;
        elapsed = now - est_last_ms;            // wraps modulo 2^32
        period  = (est_period == '0) ? 1 : longint'(est_period);
        res.upd = 1'b0;
        if (longint'(elapsed) >= period) begin
            cpr  = (est_cpr < 2) ? 2 : longint'(est_cpr);
            diff = longint'(cnt) - longint'(est_last_count);
            mag  = (diff < 0) ? -diff : diff;
            freq = MS_PER_S / longint'(elapsed);
            // More than half a revolution apart: the counter wrapped, undo it.
            if (mag > cpr / 2) begin
                if (diff > 0)
                    diff = diff - cpr;
                else
                    diff = diff + cpr;
            end
            // Bias is added whatever the sign; division truncates toward zero.
            r = (diff * freq * S_PER_MIN + cpr / 2) / cpr;
            if (r > RPM_LIMIT)
                r = RPM_LIMIT;
            if (r < -RPM_LIMIT)
                r = -RPM_LIMIT;
            est_held_rpm   = RPM_BITS'(r);
            est_last_count = cnt;
            est_last_ms    = now;
            res.upd        = 1'b1;
        end
        res.rpm = est_held_rpm;
        return res;
    endfunction

    function automatic t_dir_row sample_row(input logic [ENC_BITS-1:0]    count,
                                            input logic [TIME_BITS-1:0]   now,
                                            input logic                   typed,
                                            input logic signed [RPM_BITS-1:0] rpm,
                                            input logic                   upd);
        t_dir_row row;
        row       = '0;
        row.kind  = ROW_SAMPLE;
        row.count = count;
        row.now   = now;
        row.typed = typed;
        row.rpm   = rpm;
        row.upd   = upd;
        return row;
    endfunction

    function automatic t_dir_row cfg_row(input logic [CFG_IDX_BITS-1:0]  idx,
                                         input logic [CFG_DATA_BITS-1:0] data);
        t_dir_row row;
        row      = '0;
        row.kind = ROW_CFG;
        row.idx  = idx;
        row.data = data;
        return row;
    endfunction

    // Mostly back-to-back or short gaps, now and then a long one.
    function automatic int pick_gap(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(20, 80);
    endfunction

    // Offer one sample, hold it until the block takes it, then record what it owes.
    // Called at a rising edge; tvalid is only lowered when a gap precedes the sample.
    task automatic send_sample(input logic [ENC_BITS-1:0]  count,
                               input logic [TIME_BITS-1:0] now,
                               input bit                   steady,
                               input bit                   typed,
                               input t_speed               typed_speed);
        int     gap;
        t_speed predicted;
        gap = pick_gap(steady);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {now, count};
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = estimate_speed(count, now);
        expected_speeds.push_back(typed ? typed_speed : predicted);
    endtask

    // Drop tvalid and hold until every owed result is out and the block is idle.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_speeds.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register write transaction; only called while the block is idle.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0]  idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_IDX_CPR)
            est_cpr = data;
        else if (idx == CFG_IDX_PERIOD)
            est_period = data[PERIOD_BITS-1:0];
        @(posedge i_clk);
    endtask

    // Receiver: alternate between always ready, random backpressure and long stalls.
    always @(posedge i_clk) begin
        if (ready_left == 0) begin
            ready_mode <= t_ready_mode'($urandom_range(0, 2));
            ready_left <= $urandom_range(50, 400);
        end else begin
            ready_left <= ready_left - 1;
        end
        case (ready_mode)
            RDY_ALWAYS: begin
                m_axis_tready <= 1'b1;
            end
            RDY_RANDOM: begin
                m_axis_tready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                if (stall_left != 0) begin
                    m_axis_tready <= 1'b0;
                    stall_left    <= stall_left - 1;
                end else if ($urandom_range(0, 99) < 4) begin
                    m_axis_tready <= 1'b0;
                    stall_left    <= $urandom_range(10, 60);
                end else begin
                    m_axis_tready <= 1'b1;
                end
            end
        endcase
    end

    // Result checker: each result transaction against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_speeds.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result rpm=%0d updated=%0b", $time,
                             $signed(m_axis_tdata[RPM_BITS-1:0]), m_axis_tuser);
            end else begin
                front_speed = expected_speeds.pop_front();
                if (m_axis_tdata !== {3'b000, front_speed.rpm}) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: rpm mismatch, expected %0d (tdata %h), got tdata %h",
                                 $time, front_speed.rpm, {3'b000, front_speed.rpm},
                                 m_axis_tdata);
                end
                if (m_axis_tuser !== front_speed.upd) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: updated mismatch, expected %0b, got %0b",
                                 $time, front_speed.upd, m_axis_tuser);
                end
            end
        end
    end

    // Safety net against a hung handshake.
    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        t_dir_row             row;
        t_speed               typed_speed;
        logic [ENC_BITS-1:0]  count;
        logic [TIME_BITS-1:0] tb_ms;
        int                   tb_cnt, cpr_eff, period_eff, span, delta, mode;
        int                   sent, phase_len, pick;
        bit                   steady;
        logic [CFG_DATA_BITS-1:0] cpr_data, period_data;

        // Directed table. Reset values: 1024 counts per rev, 10 ms period.
        dir_table.push_back(sample_row(16'd0,     32'd5,  1'b1, 13'sd0,    1'b0)); // too early
        dir_table.push_back(sample_row(16'd0,     32'd10, 1'b1, 13'sd0,    1'b1)); // standstill
        dir_table.push_back(sample_row(16'd512,   32'd20, 1'b1, 13'sd3000, 1'b1)); // half rev, no wrap
        dir_table.push_back(sample_row(16'd0,     32'd21, 1'b1, 13'sd3000, 1'b0)); // held value
        dir_table.push_back(sample_row(16'd0,     32'd30, 1'b0, 13'sd0,    1'b0)); // negative rounding
        dir_table.push_back(sample_row(16'hFFFF,  32'd40, 1'b0, 13'sd0,    1'b0)); // count above modulus
        dir_table.push_back(sample_row(16'd1000, 32'hFFFF_FFFF, 1'b1, 13'sd0, 1'b1)); // freq is zero
        dir_table.push_back(sample_row(16'd1000,  32'd4,  1'b1, 13'sd0,    1'b0)); // time wrap, early
        dir_table.push_back(sample_row(16'd1010,  32'd8,  1'b1, 13'sd0,    1'b0));
        dir_table.push_back(sample_row(16'd1010,  32'd9,  1'b0, 13'sd0,    1'b0)); // across time wrap
        dir_table.push_back(cfg_row(CFG_IDX_PERIOD, 16'd0));                       // period zero
        dir_table.push_back(sample_row(16'd1020,  32'd10, 1'b0, 13'sd0,    1'b0));
        dir_table.push_back(sample_row(16'd620,   32'd11, 1'b1, -13'sd3000, 1'b1)); // saturate low
        dir_table.push_back(cfg_row(CFG_IDX_CPR, 16'd0));                          // cpr clamps to 2
        dir_table.push_back(sample_row(16'd1,     32'd12, 1'b0, 13'sd0,    1'b0));
        dir_table.push_back(sample_row(16'd1,     32'd12, 1'b0, 13'sd0,    1'b0)); // zero elapsed
        dir_table.push_back(cfg_row(CFG_IDX_CPR, 16'd1));
        dir_table.push_back(sample_row(16'd0,     32'd13, 1'b0, 13'sd0,    1'b0));
        dir_table.push_back(cfg_row(CFG_IDX_CPR, 16'hFFFF));                       // largest cpr
        dir_table.push_back(sample_row(16'hFFFE,  32'd14, 1'b0, 13'sd0,    1'b0));
        dir_table.push_back(sample_row(16'd0,     32'd1014, 1'b0, 13'sd0,  1'b0));
        dir_table.push_back(cfg_row(CFG_IDX_PERIOD, 16'hFFE8));                    // 1000, upper bits set
        dir_table.push_back(sample_row(16'd0,     32'd2013, 1'b0, 13'sd0,  1'b0));
        dir_table.push_back(sample_row(16'd0,     32'd2014, 1'b0, 13'sd0,  1'b0));
        dir_table.push_back(cfg_row(CFG_IDX_PERIOD, 16'h03FF));                    // largest period
        dir_table.push_back(sample_row(16'hFFFF, 32'h8000_0000, 1'b0, 13'sd0, 1'b0));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_table[i]) begin
            row = dir_table[i];
            if (row.kind == ROW_CFG) begin
                drain_results();
                write_reg(row.idx, row.data);
            end else begin
                typed_speed.rpm = row.rpm;
                typed_speed.upd = row.upd;
                send_sample(row.count, row.now, 1'b0, row.typed, typed_speed);
            end
        end

        // Random phases: new settings, then a run of mostly plausible encoder motion.
        tb_ms  = est_last_ms;
        tb_cnt = 0;
        sent   = 0;
        while (sent < RANDOM_SAMPLES) begin
            drain_results();
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                case ($urandom_range(0, 3))
                    0:       cpr_data = 16'd0;
                    1:       cpr_data = 16'd1;
                    2:       cpr_data = 16'd2;
                    default: cpr_data = 16'hFFFF;
                endcase
            end else if (pick < 4) begin
                cpr_data = CFG_DATA_BITS'($urandom_range(2, 64));
            end else if (pick < 8) begin
                cpr_data = CFG_DATA_BITS'($urandom_range(65, 4096));
            end else begin
                cpr_data = CFG_DATA_BITS'($urandom_range(4097, 65535));
            end
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                case ($urandom_range(0, 4))
                    0:       period_data = 16'd0;
                    1:       period_data = 16'd1;
                    2:       period_data = 16'd1000;
                    3:       period_data = 16'd1023;
                    default: period_data = CFG_DATA_BITS'($urandom_range(0, 16'hFFFF));
                endcase
            end else if (pick < 7) begin
                period_data = CFG_DATA_BITS'($urandom_range(1, 20));
            end else begin
                period_data = CFG_DATA_BITS'($urandom_range(21, 300));
            end
            write_reg(CFG_IDX_CPR, cpr_data);
            write_reg(CFG_IDX_PERIOD, period_data);

            cpr_eff    = (est_cpr < 2) ? 2 : int'(est_cpr);
            period_eff = (est_period == '0) ? 1 : int'(est_period);
            tb_cnt     = tb_cnt % cpr_eff;
            steady     = ($urandom_range(0, 3) == 0);
            phase_len  = $urandom_range(40, 110);

            for (int k = 0; k < phase_len && sent < RANDOM_SAMPLES; k++) begin
                mode  = $urandom_range(0, 99);
                // Encoder motion: small steps half of the time, up to half a rev otherwise.
                span  = ($urandom_range(0, 1) == 0) ? cpr_eff / 32 + 1 : cpr_eff / 2;
                delta = int'($urandom_range(0, 2 * span)) - span;
                tb_cnt = (tb_cnt + delta) % cpr_eff;
                if (tb_cnt < 0)
                    tb_cnt = tb_cnt + cpr_eff;
                count = ENC_BITS'(tb_cnt);
                if (mode < 65) begin
                    tb_ms = tb_ms + TIME_BITS'($urandom_range(period_eff, 2 * period_eff + 3));
                end else if (mode < 80) begin
                    tb_ms = tb_ms + TIME_BITS'($urandom_range(0, period_eff - 1));
                end else if (mode < 88) begin
                    count = ENC_BITS'($urandom_range(0, 16'hFFFF)); // noise, may exceed the modulus
                    tb_ms = tb_ms + TIME_BITS'($urandom_range(0, 2 * period_eff));
                end else if (mode < 94) begin
                    tb_ms = $urandom();                    // clock jump, either direction
                end else begin
                    tb_ms = 32'hFFFF_FFFF - TIME_BITS'($urandom_range(0, 2 * period_eff));
                end
                send_sample(count, tb_ms, steady, 1'b0, '0);
                sent++;
                // Now and then hold the sender until the pipeline is empty.
                if ($urandom_range(0, 99) < 2)
                    drain_results();
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_speeds.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
